// ----- hdl/ccl_pkg.sv -----
`timescale 1ns / 1ps
package ccl_pkg;

  localparam int MAX_DIM     = 1024;
  localparam int MAX_ENTRIES = 4096;
  localparam int SLOT_DEPTH  = MAX_ENTRIES + MAX_DIM;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 10;
  localparam int Q_W    = 13;
  localparam int DIM_W  = 11;
  localparam int CNT_W  = 13;
  localparam int SLOT_W = 13;
  localparam int ANS_W  = 14;
  localparam int CFG_W  = 11;
  localparam int REG_W  = 2;

  localparam int ENT_AW  = $clog2(MAX_ENTRIES);
  localparam int SLOT_AW = $clog2(SLOT_DEPTH);
  localparam int COL_AW  = $clog2(MAX_DIM + 1);

  localparam logic [REG_W-1:0] REG_DIM = 2'd0;
  localparam logic [REG_W-1:0] REG_POS = 2'd1;
  localparam logic [REG_W-1:0] REG_NEG = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD     = 3'd0,
    OP_BUILD    = 3'd1,
    OP_READ_ROW = 3'd2,
    OP_READ_COL = 3'd3,
    OP_READ_MAP = 3'd4,
    OP_PIVOT    = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESP,
    ST_CHECK,
    ST_COL,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic accept;
    logic check_run;
    logic scan_run;
    logic col_begin;
    logic col_advance;
    logic row_advance;
    logic read_done;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic scan_done;
    logic col_end;
    logic found;
  } status_t;

endpackage

// ----- hdl/ccl_ram.sv -----
`timescale 1ns / 1ps
module ccl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ccl_ctrl.sv -----
`timescale 1ns / 1ps
module ccl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  ccl_pkg::op_t           op,
  input  ccl_pkg::status_t       sts,
  output logic                   s_tready,
  output ccl_pkg::cmd_t          cmd
);

  ccl_pkg::state_t state;
  ccl_pkg::state_t state_next;
  logic            accept;

  assign s_tready = (state == ccl_pkg::ST_IDLE) && !sts.out_busy;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ccl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op) inside
            ccl_pkg::OP_BUILD: state_next = ccl_pkg::ST_CHECK;
            ccl_pkg::OP_READ_ROW, ccl_pkg::OP_READ_COL, ccl_pkg::OP_READ_MAP:
              state_next = ccl_pkg::ST_RESP;
            default: state_next = ccl_pkg::ST_IDLE;
          endcase
        end
      end
      ccl_pkg::ST_RESP:  state_next = ccl_pkg::ST_IDLE;
      ccl_pkg::ST_CHECK: begin
        if (sts.scan_done) state_next = ccl_pkg::ST_COL;
      end
      ccl_pkg::ST_COL: begin
        state_next = sts.col_end ? ccl_pkg::ST_IDLE : ccl_pkg::ST_SCAN;
      end
      ccl_pkg::ST_SCAN: begin
        if (sts.scan_done && !sts.found) state_next = ccl_pkg::ST_COL;
      end
      default: state_next = ccl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ccl_pkg::ST_IDLE:  cmd.accept    = accept;
      ccl_pkg::ST_RESP:  cmd.read_done = 1'b1;
      ccl_pkg::ST_CHECK: cmd.check_run = 1'b1;
      ccl_pkg::ST_COL:   cmd.col_begin = 1'b1;
      ccl_pkg::ST_SCAN: begin
        cmd.scan_run    = 1'b1;
        cmd.row_advance = sts.scan_done && sts.found;
        cmd.col_advance = sts.scan_done && !sts.found;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hdl/ccl_datapath.sv -----
`timescale 1ns / 1ps
module ccl_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [ccl_pkg::REG_W-1:0]   cfg_index,
  input  logic [ccl_pkg::CFG_W-1:0]   cfg_data,
  input  ccl_pkg::op_t                op,
  input  logic [ccl_pkg::IDX_W-1:0]   entry_row,
  input  logic [ccl_pkg::IDX_W-1:0]   entry_column,
  input  logic [ccl_pkg::Q_W-1:0]     query_index,
  input  ccl_pkg::cmd_t               cmd,
  output ccl_pkg::status_t            sts,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [ccl_pkg::ANS_W-1:0]   answer,
  output logic                        error
);

  localparam int IW = ccl_pkg::IDX_W;

  // configuration
  logic [ccl_pkg::CFG_W-1:0] cfg_dim, cfg_pos, cfg_neg;
  logic [ccl_pkg::DIM_W-1:0] dim;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_dim <= ccl_pkg::CFG_W'(1);
      cfg_pos <= '0;
      cfg_neg <= '0;
    end else if (cfg_write) begin
      if (cfg_index == ccl_pkg::REG_DIM) cfg_dim <= cfg_data;
      if (cfg_index == ccl_pkg::REG_POS) cfg_pos <= cfg_data;
      if (cfg_index == ccl_pkg::REG_NEG) cfg_neg <= cfg_data;
    end
  end

  always_comb begin
    if (cfg_dim == '0) begin
      dim = ccl_pkg::DIM_W'(1);
    end else if (cfg_dim > ccl_pkg::CFG_W'(ccl_pkg::MAX_DIM)) begin
      dim = ccl_pkg::DIM_W'(ccl_pkg::MAX_DIM);
    end else begin
      dim = ccl_pkg::DIM_W'(cfg_dim);
    end
  end

  // build state
  logic [ccl_pkg::CNT_W-1:0]  loaded_count;
  logic [ccl_pkg::SLOT_W-1:0] unique_count;
  logic [ccl_pkg::DIM_W-1:0]  built_dim;
  logic                       built;
  logic [ccl_pkg::CNT_W-1:0]  e;
  logic                       d_v, d_check;
  logic [ccl_pkg::ENT_AW-1:0] d_idx;
  logic [ccl_pkg::DIM_W-1:0]  c;
  logic [ccl_pkg::SLOT_W-1:0] slot;
  logic [IW-1:0]              cur, min_row;
  logic                       found, err_acc;

  // memories
  logic                         ent_we;
  logic [2*IW-1:0]              ent_rdata;
  logic                         map_we;
  logic [ccl_pkg::SLOT_W-1:0]   map_wdata, map_rdata;
  logic                         csc_we;
  logic [ccl_pkg::SLOT_AW-1:0]  csc_waddr;
  logic [IW-1:0]                csc_wdata, csc_rdata;
  logic [ccl_pkg::SLOT_W-1:0]   col_rdata;

  logic run, issue, build_done;
  logic [IW-1:0] d_row, d_col;
  logic ent_ok, col_match;
  logic load_ok;

  assign run        = cmd.check_run || cmd.scan_run;
  assign issue      = run && (e < loaded_count);
  assign build_done = cmd.col_begin && sts.col_end;

  assign d_row = ent_rdata[IW-1:0];
  assign d_col = ent_rdata[2*IW-1:IW];
  assign ent_ok = ({1'b0, d_row} < dim) && ({1'b0, d_col} < dim) && (d_row >= d_col);
  assign col_match = ent_ok && ({1'b0, d_col} == c);

  assign sts.scan_done = !issue && !d_v;
  assign sts.col_end   = (c == dim);
  assign sts.found     = found;
  assign sts.out_busy  = m_tvalid && !m_tready;

  assign load_ok = (loaded_count < ccl_pkg::CNT_W'(ccl_pkg::MAX_ENTRIES)) &&
                   ({1'b0, entry_row} < dim) && ({1'b0, entry_column} < dim) &&
                   (entry_row >= entry_column);
  assign ent_we = cmd.accept && (op == ccl_pkg::OP_LOAD) && load_ok;

  // check pass clears the map of entries that fell outside the dimension
  assign map_we = d_v && (d_check ? !ent_ok : (col_match && d_row == cur));
  assign map_wdata = d_check ? '0 : slot;

  assign csc_we    = (cmd.col_begin && !sts.col_end) || cmd.row_advance;
  assign csc_waddr = cmd.row_advance ? ccl_pkg::SLOT_AW'(slot + 1'b1) :
                                       ccl_pkg::SLOT_AW'(slot);
  assign csc_wdata = cmd.row_advance ? min_row : c[IW-1:0];

  ccl_ram #(.WIDTH(2*IW), .DEPTH(ccl_pkg::MAX_ENTRIES)) u_ent (
    .clk   (clk),
    .we    (ent_we),
    .waddr (loaded_count[ccl_pkg::ENT_AW-1:0]),
    .wdata ({entry_column, entry_row}),
    .raddr (e[ccl_pkg::ENT_AW-1:0]),
    .rdata (ent_rdata)
  );

  ccl_ram #(.WIDTH(ccl_pkg::SLOT_W), .DEPTH(ccl_pkg::MAX_ENTRIES)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (d_idx),
    .wdata (map_wdata),
    .raddr (query_index[ccl_pkg::ENT_AW-1:0]),
    .rdata (map_rdata)
  );

  ccl_ram #(.WIDTH(IW), .DEPTH(ccl_pkg::SLOT_DEPTH)) u_csc (
    .clk   (clk),
    .we    (csc_we),
    .waddr (csc_waddr),
    .wdata (csc_wdata),
    .raddr (query_index[ccl_pkg::SLOT_AW-1:0]),
    .rdata (csc_rdata)
  );

  ccl_ram #(.WIDTH(ccl_pkg::SLOT_W), .DEPTH(ccl_pkg::MAX_DIM + 1)) u_col (
    .clk   (clk),
    .we    (cmd.col_begin),
    .waddr (c[ccl_pkg::COL_AW-1:0]),
    .wdata (slot),
    .raddr (query_index[ccl_pkg::COL_AW-1:0]),
    .rdata (col_rdata)
  );

  // entry scan, one read issued a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else begin
      d_v <= issue;
    end
    d_idx   <= e[ccl_pkg::ENT_AW-1:0];
    d_check <= cmd.check_run;

    if ((cmd.accept && op == ccl_pkg::OP_BUILD) || cmd.col_begin || cmd.row_advance) begin
      e <= '0;
    end else if (issue) begin
      e <= e + 1'b1;
    end

    if (cmd.accept && op == ccl_pkg::OP_BUILD) begin
      err_acc <= 1'b0;
      c       <= '0;
      slot    <= '0;
    end else if (d_v && d_check && !ent_ok) begin
      err_acc <= 1'b1;
    end

    if (cmd.col_begin || cmd.row_advance) begin
      found <= 1'b0;
    end else if (d_v && !d_check && col_match && d_row > cur && (!found || d_row < min_row)) begin
      found   <= 1'b1;
      min_row <= d_row;
    end

    if (cmd.col_begin && !sts.col_end) begin
      cur <= c[IW-1:0];
    end
    if (cmd.row_advance) begin
      cur  <= min_row;
      slot <= slot + 1'b1;
    end
    if (cmd.col_advance) begin
      slot <= slot + 1'b1;
      c    <= c + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count <= '0;
      unique_count <= '0;
      built_dim    <= '0;
      built        <= 1'b0;
    end else begin
      if (ent_we) loaded_count <= loaded_count + 1'b1;
      if (build_done) begin
        unique_count <= slot;
        built_dim    <= dim;
        built        <= 1'b1;
      end
    end
  end

  // read commands: range check at transfer, memory data in the cycle after
  ccl_pkg::op_t rd_op;
  logic         rd_err;
  logic         acc_err;

  always_comb begin
    case (op)
      ccl_pkg::OP_READ_ROW: acc_err = !(query_index < unique_count);
      ccl_pkg::OP_READ_COL: acc_err = !(query_index <= ccl_pkg::Q_W'(built_dim));
      ccl_pkg::OP_READ_MAP: acc_err = !(query_index < loaded_count);
      default:              acc_err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_op  <= op;
      rd_err <= acc_err;
    end
  end

  // immediate answers
  logic [ccl_pkg::ANS_W-1:0] imm_answer;
  logic                      imm_error;
  logic                      imm_valid;
  logic [ccl_pkg::DIM_W:0]   pivot_sum;

  assign pivot_sum = {1'b0, cfg_pos} + {1'b0, cfg_neg};

  always_comb begin
    imm_answer = '0;
    imm_error  = 1'b0;
    imm_valid  = 1'b0;
    case (op)
      ccl_pkg::OP_LOAD: begin
        imm_valid  = 1'b1;
        imm_error  = !load_ok;
        imm_answer = load_ok ? ccl_pkg::ANS_W'(loaded_count + 1'b1) :
                               ccl_pkg::ANS_W'(loaded_count);
      end
      ccl_pkg::OP_BUILD, ccl_pkg::OP_READ_ROW, ccl_pkg::OP_READ_COL,
      ccl_pkg::OP_READ_MAP: begin
        imm_valid = 1'b0;
      end
      ccl_pkg::OP_PIVOT: begin
        imm_valid = 1'b1;
        if (!(query_index < ccl_pkg::Q_W'(dim))) begin
          imm_error = 1'b1;
        end else if (query_index < ccl_pkg::Q_W'(cfg_pos)) begin
          imm_answer = ccl_pkg::ANS_W'(1);
        end else if (query_index < ccl_pkg::Q_W'(pivot_sum)) begin
          imm_answer = '1;
        end
      end
      default: begin
        imm_valid = 1'b1;
        imm_error = 1'b1;
      end
    endcase
  end

  logic [ccl_pkg::ANS_W-1:0] rd_answer;

  always_comb begin
    rd_answer = '0;
    if (!rd_err) begin
      case (rd_op)
        ccl_pkg::OP_READ_ROW: rd_answer = ccl_pkg::ANS_W'(csc_rdata);
        ccl_pkg::OP_READ_COL: rd_answer = built ? ccl_pkg::ANS_W'(col_rdata) : '0;
        ccl_pkg::OP_READ_MAP: rd_answer = ccl_pkg::ANS_W'(map_rdata);
        default:              rd_answer = '0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((cmd.accept && imm_valid) || cmd.read_done || build_done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.accept && imm_valid) begin
      answer <= imm_answer;
      error  <= imm_error;
    end else if (cmd.read_done) begin
      answer <= rd_answer;
      error  <= rd_err;
    end else if (build_done) begin
      answer <= ccl_pkg::ANS_W'(slot);
      error  <= err_acc;
    end
  end

endmodule

// ----- hdl/coo_to_csc_lower_pattern.sv -----
`timescale 1ns / 1ps
// channel  direction  fields (lowest bit up)
// s_       in         tdata: entry_row, entry_column, query_index; tuser: op
// m_       out        tdata: answer, error
// cfg_     in         write enable, register index, data
//
// load, pivot sign and undefined ops answer in the cycle after transfer; row, column
// and map reads first pass a registered memory read. a build steps through every
// column; the entry store's one read port is swept once to check entries and once for
// every slot found, one entry a cycle, each sweep ending with a drain of the read.
// reset is synchronous; counts clear, memories hold until written.
// a result waiting in the output register holds off the next input transfer.
module coo_to_csc_lower_pattern (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [ccl_pkg::REG_W-1:0] cfg_index,
  input  logic [ccl_pkg::CFG_W-1:0] cfg_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [39:0]               s_tdata,  // entry_row, entry_column, query_index
  input  logic [ccl_pkg::OP_W-1:0]  s_tuser,  // op
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata   // answer, error
);

  ccl_pkg::cmd_t    cmd;
  ccl_pkg::status_t sts;
  ccl_pkg::op_t     op;
  logic [ccl_pkg::ANS_W-1:0] answer;
  logic                      error;

  assign op = ccl_pkg::op_t'(s_tuser);
  assign m_tdata = {1'b0, error, answer};

  ccl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (op),
    .sts      (sts),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  ccl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .op           (op),
    .entry_row    (s_tdata[9:0]),
    .entry_column (s_tdata[19:10]),
    .query_index  (s_tdata[32:20]),
    .cmd          (cmd),
    .sts          (sts),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .answer       (answer),
    .error        (error)
  );

`ifndef ASSERT_OFF
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !(m_tvalid && !m_tready))
    else $error("input ready while result is stalled");

  a_read_takes_two: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == ccl_pkg::OP_READ_ROW ||
     s_tuser == ccl_pkg::OP_READ_COL || s_tuser == ccl_pkg::OP_READ_MAP)) |=> !s_tready)
    else $error("read did not wait for memory data");

  a_build_no_early_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == ccl_pkg::OP_BUILD) |=> !m_tvalid)
    else $error("build gave a result at once");
`endif

endmodule

// ----- test/tb_coo_to_csc_lower_pattern.sv -----
`timescale 1ns / 1ps
module tb_coo_to_csc_lower_pattern;

  localparam logic [ccl_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [ccl_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef struct {
    logic [ccl_pkg::OP_W-1:0]  op;
    logic [ccl_pkg::IDX_W-1:0] row;
    logic [ccl_pkg::IDX_W-1:0] col;
    logic [ccl_pkg::Q_W-1:0]   q;
  } cmd_t;

  typedef struct {
    logic [ccl_pkg::ANS_W-1:0] answer;
    logic                      error;
  } reply_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [ccl_pkg::REG_W-1:0]  cfg_index = '0;
  logic [ccl_pkg::CFG_W-1:0]  cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [39:0]                s_tdata = '0;
  logic [ccl_pkg::OP_W-1:0]   s_tuser = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [15:0]                m_tdata;

  coo_to_csc_lower_pattern i_dut (.*);

  always #5 clk = ~clk;

  cmd_t   pending_cmds[$];
  reply_t expected_replies[$];
  bit     failed = 1'b0;
  bit     bursty = 1'b1;

  // shadow of the pattern store
  int unsigned sh_dim_reg = 1, sh_pos = 0, sh_neg = 0;
  int unsigned sh_rows[ccl_pkg::MAX_ENTRIES], sh_cols[ccl_pkg::MAX_ENTRIES];
  int unsigned sh_count = 0, sh_unique = 0, sh_built_dim = 0;
  int unsigned sh_row_idx[ccl_pkg::SLOT_DEPTH], sh_col_start[ccl_pkg::MAX_DIM+1];
  int unsigned sh_slot_of[ccl_pkg::MAX_ENTRIES];
  int unsigned order[ccl_pkg::MAX_ENTRIES];

  function automatic int unsigned eff_dim(int unsigned d);
    if (d == 0) return 1;
    if (d > ccl_pkg::MAX_DIM) return ccl_pkg::MAX_DIM;
    return d;
  endfunction

  function automatic bit build_pattern();
    int unsigned d, nv, e, j, k, c, s, slot, prev, r;
    bit bad, diag, have_prev;
    d = eff_dim(sh_dim_reg);
    nv = 0; bad = 0; s = 0; slot = 0;
    for (e = 0; e < sh_count; e++) begin
      if (sh_rows[e] < d && sh_cols[e] < d && sh_rows[e] >= sh_cols[e]) begin
        // stable insertion by column then row
        j = nv;
        while (j > 0 && (sh_cols[order[j-1]] > sh_cols[e] ||
               (sh_cols[order[j-1]] == sh_cols[e] && sh_rows[order[j-1]] > sh_rows[e]))) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = e;
        nv++;
      end else begin
        sh_slot_of[e] = 0;
        bad = 1;
      end
    end
    for (c = 0; c < d; c++) begin
      diag = 0; have_prev = 0; prev = 0;
      sh_col_start[c] = slot;
      while (s < nv && sh_cols[order[s]] == c) begin
        k = order[s];
        r = sh_rows[k];
        if (!diag && r > c) begin
          sh_row_idx[slot++] = c;
          diag = 1; prev = c; have_prev = 1;
        end
        if (!have_prev || r != prev) begin
          sh_row_idx[slot++] = r;
          prev = r; have_prev = 1;
          if (r == c) diag = 1;
        end
        sh_slot_of[k] = slot - 1;
        s++;
      end
      if (!diag) sh_row_idx[slot++] = c;
    end
    sh_col_start[d] = slot;
    sh_unique = slot;
    sh_built_dim = d;
    return bad;
  endfunction

  function automatic reply_t predict_reply(cmd_t t);
    int unsigned d, q;
    int ans;
    bit bad;
    reply_t rp;
    d = eff_dim(sh_dim_reg);
    q = t.q;
    ans = 0; bad = 0;
    case (t.op)
      ccl_pkg::OP_LOAD: begin
        if (sh_count >= ccl_pkg::MAX_ENTRIES || t.row >= d || t.col >= d || t.row < t.col)
          bad = 1;
        else begin
          sh_rows[sh_count] = t.row;
          sh_cols[sh_count] = t.col;
          sh_count++;
        end
        ans = sh_count;
      end
      ccl_pkg::OP_BUILD: begin
        bad = build_pattern();
        ans = sh_unique;
      end
      ccl_pkg::OP_READ_ROW: if (q < sh_unique) ans = sh_row_idx[q]; else bad = 1;
      ccl_pkg::OP_READ_COL: if (q <= sh_built_dim) ans = sh_col_start[q]; else bad = 1;
      ccl_pkg::OP_READ_MAP: if (q < sh_count) ans = sh_slot_of[q]; else bad = 1;
      ccl_pkg::OP_PIVOT: begin
        if (q >= d) bad = 1;
        else if (q < sh_pos) ans = 1;
        else if (q < sh_pos + sh_neg) ans = -1;
      end
      default: bad = 1;
    endcase
    if (bad && t.op >= ccl_pkg::OP_READ_ROW) ans = 0;
    rp.answer = ans[ccl_pkg::ANS_W-1:0];
    rp.error = bad;
    return rp;
  endfunction

  // driver
  cmd_t cur_cmd;
  int   src_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_replies.insert(expected_replies.size(), predict_reply(cur_cmd));
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_tdata <= {7'b0, cur_cmd.q, cur_cmd.col, cur_cmd.row};
          s_tuser <= cur_cmd.op;
          s_tvalid <= 1'b1;
          if (bursty && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 9);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int sink_stall = 0;
  always @(posedge clk) begin
    reply_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected transfer: answer %0d error %0b", m_tdata[13:0], m_tdata[14]);
          failed = 1'b1;
        end else begin
          want = expected_replies.pop_front();
          if (m_tdata[13:0] !== want.answer) begin
            $error("answer: expected %0d, got %0d", $signed(want.answer), $signed(m_tdata[13:0]));
            failed = 1'b1;
          end
          if (m_tdata[14] !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, m_tdata[14]);
            failed = 1'b1;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else if (bursty && $urandom_range(0, 7) == 0) begin
        sink_stall = $urandom_range(1, 9);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // stimulus-side bookkeeping, used to steer generated indices and keep map reads legal
  int unsigned gen_dim = 1, gen_count = 0, gen_built = 0;

  task automatic push_cmd(logic [ccl_pkg::OP_W-1:0] op, int unsigned r, int unsigned c,
                          int unsigned q);
    cmd_t t;
    t.op = op;
    t.row = ccl_pkg::IDX_W'(r);
    t.col = ccl_pkg::IDX_W'(c);
    t.q = ccl_pkg::Q_W'(q);
    if (op == ccl_pkg::OP_LOAD && gen_count < ccl_pkg::MAX_ENTRIES &&
        r < gen_dim && c < gen_dim && r >= c)
      gen_count++;
    if (op == ccl_pkg::OP_BUILD) gen_built = gen_count;
    // never touch map entries loaded after the last build
    if (op == ccl_pkg::OP_READ_MAP && t.q >= gen_built && t.q < gen_count)
      t.q = ccl_pkg::Q_W'(gen_count);
    pending_cmds.insert(pending_cmds.size(), t);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || expected_replies.size() > 0 || s_tvalid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [ccl_pkg::REG_W-1:0] idx, int unsigned v);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= ccl_pkg::CFG_W'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      ccl_pkg::REG_DIM: begin
        sh_dim_reg = v & 11'h7ff;
        gen_dim = eff_dim(sh_dim_reg);
      end
      ccl_pkg::REG_POS: sh_pos = v & 11'h7ff;
      ccl_pkg::REG_NEG: sh_neg = v & 11'h7ff;
      default: ;
    endcase
  endtask

  task automatic random_phase(int n);
    int unsigned c, k, q;
    for (k = 0; k < n; k++) begin
      if (k == n / 2 || k == n - 1) begin
        push_cmd(ccl_pkg::OP_BUILD, 0, 0, 0);
        continue;
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          c = $urandom_range(0, gen_dim - 1);
          push_cmd(ccl_pkg::OP_LOAD, $urandom_range(c, gen_dim - 1), c, 0);
        end
        8, 9, 10: push_cmd(ccl_pkg::OP_READ_ROW, 0, 0,
                           $urandom_range(0, gen_count + gen_dim + 2));
        11, 12: push_cmd(ccl_pkg::OP_READ_COL, 0, 0, $urandom_range(0, gen_dim + 1));
        13, 14: begin
          if (gen_built > 0 && $urandom_range(0, 3) != 0)
            q = $urandom_range(0, gen_built - 1);
          else q = gen_count + $urandom_range(0, 3);
          push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, q);
        end
        15, 16: push_cmd(ccl_pkg::OP_PIVOT, 0, 0, $urandom_range(0, gen_dim + 1));
        default: begin
          // noise over the full field ranges
          q = $urandom_range(0, 7);
          if (q == ccl_pkg::OP_BUILD) q = ccl_pkg::OP_PIVOT;
          push_cmd(ccl_pkg::OP_W'(q), $urandom_range(0, 1023), $urandom_range(0, 1023),
                   $urandom_range(0, 8191));
        end
      endcase
    end
  endtask

  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fresh state, dimension one
    push_cmd(ccl_pkg::OP_PIVOT, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_ROW, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_COL, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_COL, 0, 0, 1);
    push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, 0);
    push_cmd(OP_UNDEF_LO, 0, 0, 0);
    push_cmd(OP_UNDEF_HI, 1023, 1023, 8191);
    push_cmd(ccl_pkg::OP_LOAD, 0, 0, 0);
    push_cmd(ccl_pkg::OP_LOAD, 1, 0, 0);
    push_cmd(ccl_pkg::OP_BUILD, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_ROW, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, 0);

    // duplicates, missing and explicit diagonals, row below column
    write_reg(ccl_pkg::REG_DIM, 8);
    write_reg(ccl_pkg::REG_POS, 3);
    write_reg(ccl_pkg::REG_NEG, 2);
    push_cmd(ccl_pkg::OP_LOAD, 7, 0, 0);
    push_cmd(ccl_pkg::OP_LOAD, 3, 3, 0);
    push_cmd(ccl_pkg::OP_LOAD, 5, 3, 0);
    push_cmd(ccl_pkg::OP_LOAD, 5, 3, 0);
    push_cmd(ccl_pkg::OP_LOAD, 2, 5, 0);
    push_cmd(ccl_pkg::OP_LOAD, 9, 1, 0);
    push_cmd(ccl_pkg::OP_BUILD, 0, 0, 0);
    for (p = 0; p < 12; p++) push_cmd(ccl_pkg::OP_READ_ROW, 0, 0, p);
    for (p = 0; p < 10; p++) push_cmd(ccl_pkg::OP_READ_COL, 0, 0, p);
    for (p = 0; p < 6; p++) push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, p);
    for (p = 0; p < 9; p++) push_cmd(ccl_pkg::OP_PIVOT, 0, 0, p);

    // largest dimension and top indices
    write_reg(ccl_pkg::REG_DIM, 1024);
    write_reg(ccl_pkg::REG_POS, 1024);
    write_reg(ccl_pkg::REG_NEG, 0);
    push_cmd(ccl_pkg::OP_LOAD, 1023, 1023, 0);
    push_cmd(ccl_pkg::OP_LOAD, 1023, 0, 0);
    push_cmd(ccl_pkg::OP_LOAD, 512, 200, 0);
    push_cmd(ccl_pkg::OP_BUILD, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_COL, 0, 0, 1024);
    push_cmd(ccl_pkg::OP_READ_COL, 0, 0, 1025);
    push_cmd(ccl_pkg::OP_READ_ROW, 0, 0, 1030);
    push_cmd(ccl_pkg::OP_PIVOT, 0, 0, 1023);
    push_cmd(ccl_pkg::OP_PIVOT, 0, 0, 1024);

    // register values beyond range, then dimension shrunk under loaded entries
    write_reg(ccl_pkg::REG_DIM, 2047);
    write_reg(ccl_pkg::REG_POS, 0);
    write_reg(ccl_pkg::REG_NEG, 2047);
    push_cmd(ccl_pkg::OP_PIVOT, 0, 0, 1023);
    write_reg(ccl_pkg::REG_DIM, 0);
    push_cmd(ccl_pkg::OP_BUILD, 0, 0, 0);
    push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, 1);
    push_cmd(ccl_pkg::OP_READ_COL, 0, 0, 1);
    push_cmd(ccl_pkg::OP_PIVOT, 0, 0, 0);

    for (p = 0; p < 8; p++) begin
      write_reg(ccl_pkg::REG_DIM, (p == 0) ? 64 : $urandom_range(2, 16));
      write_reg(ccl_pkg::REG_POS, $urandom_range(0, gen_dim + 2));
      write_reg(ccl_pkg::REG_NEG, $urandom_range(0, gen_dim + 2));
      if (p == 7) begin
        wait_idle();
        bursty = 1'b0;
      end
      random_phase(150);
    end

    // loads after the last build and reads at the top of the map range
    write_reg(ccl_pkg::REG_DIM, 1024);
    push_cmd(ccl_pkg::OP_LOAD, 5, 5, 0);
    push_cmd(ccl_pkg::OP_LOAD, 1023, 0, 0);
    push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, gen_built - 1);
    push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, ccl_pkg::MAX_ENTRIES);
    push_cmd(ccl_pkg::OP_READ_MAP, 0, 0, 8191);

    wait_idle();
    repeat (20) @(posedge clk);
    if (!failed) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/ccl_pkg.sv
hdl/ccl_ram.sv
hdl/ccl_ctrl.sv
hdl/ccl_datapath.sv
hdl/coo_to_csc_lower_pattern.sv
test/tb_coo_to_csc_lower_pattern.sv
